// File: rtl/pbp_pkg.sv
`default_nettype none

package pbp_pkg;

    // Fixed field widths of the stream.
    localparam int WORD_W       = 64;
    localparam int PKT_LEN_W    = 14;
    localparam int MASK_W       = 8;

    // Bytes carried by one input word, and the bits needed to count 0..8 of them.
    localparam int BYTES_PER_WORD = 8;
    localparam int BYTE_CNT_W     = $clog2(BYTES_PER_WORD + 1);

    // Full byte mask of one word.
    localparam logic [MASK_W-1:0] MASK_FULL = 8'hff;

    // Default limit on the sampled packet length.
    localparam int MAX_PACKET_BYTES_DEF = 16383;

    // Per-word result of the length tracker.
    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              last;
    } t_word_info;

    // One 128-bit output beat.
    typedef struct packed {
        logic [WORD_W-1:0] beat_low;
        logic [WORD_W-1:0] beat_high;
        logic [MASK_W-1:0] mask_low;
        logic [MASK_W-1:0] mask_high;
        logic              start_of_packet;
        logic              end_of_packet;
    } t_beat;

    // Status of the pairing stage.
    typedef struct packed {
        logic holding;
        logic first_pending;
    } t_pair_status;

endpackage

`default_nettype wire

// File: rtl/pbp_stream_if.sv
`default_nettype none

// Input channel: one 64-bit packet word per request.
interface pbp_in_if;
    import pbp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WORD_W-1:0]    data_word;
    logic [PKT_LEN_W-1:0] packet_length;

    modport source (output valid, output data_word, output packet_length, input ready);
    modport sink   (input valid, input data_word, input packet_length, output ready);
endinterface

// Output channel: one 128-bit beat per request.
interface pbp_out_if;
    import pbp_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] beat_low;
    logic [WORD_W-1:0] beat_high;
    logic [MASK_W-1:0] mask_low;
    logic [MASK_W-1:0] mask_high;
    logic              start_of_packet;
    logic              end_of_packet;

    modport source (output valid, output beat_low, output beat_high, output mask_low,
                    output mask_high, output start_of_packet, output end_of_packet,
                    input ready);
    modport sink   (input valid, input beat_low, input beat_high, input mask_low,
                    input mask_high, input start_of_packet, input end_of_packet,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/packet_beat_packer_64_to_128.sv
`default_nettype none

// Packet beat packer, 64-bit words in, 128-bit beats out. Each request on the
// input carries one word of a packet, byte 0 in the low bits; packet_length is
// sampled only on a packet's first word and is saturated to MAX_PACKET_BYTES.
// A length of zero makes a one-word packet with an all-zero mask. Each word gets
// a byte mask that is full while more than eight bytes remain and otherwise has
// the low remaining bits set. Words are paired into beats, the earlier word in
// the low half; a beat leaves on every second word and on the last word of a
// packet, where an odd last word leaves alone with a zero high half and mask.
// The block takes one word per clock while its input ready is high: the input
// register stage (the length tracker and the held low half) feeds the output
// register directly, so a beat appears in the cycle after the word that completes
// it. Input ready is high while the output register is empty or being drained,
// so a stalled output holds the input back after at most one finished beat.
module packet_beat_packer_64_to_128 #(
    parameter int MAX_PACKET_BYTES = pbp_pkg::MAX_PACKET_BYTES_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pbp_in_if.sink      i_in,
    pbp_out_if.source   o_out
);
    import pbp_pkg::*;

    localparam int REM_W = $clog2(MAX_PACKET_BYTES + 1);

    logic             w_accept;
    logic             w_out_valid;
    t_word_info       w_info;
    t_beat            w_beat;
    t_pair_status     w_status;
    logic [REM_W-1:0] w_bytes_remaining;

    // A word is taken whenever the output register can hold the beat it may finish.
    assign i_in.ready = !w_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    // Length tracking and byte mask for the word at the input.
    pbp_len #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_len (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (w_accept),
        .i_packet_length   (i_in.packet_length),
        .o_info            (w_info),
        .o_bytes_remaining (w_bytes_remaining)
    );

    // Pairing of words into beats, with the output register.
    pbp_pair u_pair (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_word      (i_in.data_word),
        .i_info      (w_info),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .o_beat      (w_beat),
        .o_status    (w_status)
    );

    assign o_out.valid           = w_out_valid;
    assign o_out.beat_low        = w_beat.beat_low;
    assign o_out.beat_high       = w_beat.beat_high;
    assign o_out.mask_low        = w_beat.mask_low;
    assign o_out.mask_high       = w_beat.mask_high;
    assign o_out.start_of_packet = w_beat.start_of_packet;
    assign o_out.end_of_packet   = w_beat.end_of_packet;

`ifndef SYNTHESIS
    // A word that completes a held low half always produces a beat next cycle.
    a_pair_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_status.holding) |=> o_out.valid)
        else $error("paired word did not produce a beat");

    // The remaining byte count never exceeds the configured limit.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bytes_remaining <= REM_W'(MAX_PACKET_BYTES))
        else $error("bytes remaining above limit");

    // A high half only carries bytes when the low half was full.
    a_high_needs_full_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.mask_high == '0 || o_out.mask_low == MASK_FULL))
        else $error("high mask set with partial low mask");

    // While a low half is held, the packet cannot be between packets.
    a_hold_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.holding |-> (w_bytes_remaining != '0))
        else $error("low half held with no bytes remaining");
`endif

endmodule

`default_nettype wire

// File: rtl/pbp_len.sv
`default_nettype none

// Tracks the bytes left in the current packet and derives each word's byte mask.
module pbp_len #(
    parameter int MAX_PACKET_BYTES = pbp_pkg::MAX_PACKET_BYTES_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_accept,
    input  wire logic [pbp_pkg::PKT_LEN_W-1:0]           i_packet_length,
    output pbp_pkg::t_word_info                          o_info,
    output logic [$clog2(MAX_PACKET_BYTES+1)-1:0]        o_bytes_remaining
);
    import pbp_pkg::*;

    localparam int REM_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam int CMP_W = (REM_W > PKT_LEN_W) ? REM_W : PKT_LEN_W;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_PACKET_BYTES);

    logic [REM_W-1:0]      r_rem;
    logic [REM_W-1:0]      n_rem;
    logic [CMP_W-1:0]      w_len_ext;
    logic [REM_W-1:0]      w_sampled;
    logic [REM_W-1:0]      w_cur;
    logic                  w_more;
    logic [MASK_W:0]       w_one_hot;
    logic [MASK_W:0]       w_mask_full;

    always_comb begin
        w_len_ext = CMP_W'(i_packet_length);
        w_sampled = (w_len_ext > MAX_CMP) ? MAX_CMP[REM_W-1:0] : w_len_ext[REM_W-1:0];
        // A packet starts on the word that arrives with nothing left to count.
        w_cur     = (r_rem == '0) ? w_sampled : r_rem;
        w_more    = w_cur > REM_W'(BYTES_PER_WORD);
        // For a tail word the low w_cur bits are set; eight wraps to a full mask.
        w_one_hot   = (MASK_W+1)'(1) << w_cur[BYTE_CNT_W-1:0];
        w_mask_full = w_one_hot - (MASK_W+1)'(1);
        o_info.mask = w_more ? MASK_FULL : w_mask_full[MASK_W-1:0];
        o_info.last = !w_more;
        n_rem       = w_more ? (w_cur - REM_W'(BYTES_PER_WORD)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_accept) begin
            r_rem <= n_rem;
        end
    end

    assign o_bytes_remaining = r_rem;

endmodule

`default_nettype wire

// File: rtl/pbp_pair.sv
`default_nettype none

// Pairs words into beats and holds the finished beat in the output register.
module pbp_pair (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [pbp_pkg::WORD_W-1:0]    i_word,
    input  wire pbp_pkg::t_word_info           i_info,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output pbp_pkg::t_beat                     o_beat,
    output pbp_pkg::t_pair_status              o_status
);
    import pbp_pkg::*;

    logic [WORD_W-1:0] r_held_word;
    logic [MASK_W-1:0] r_held_mask;
    logic              r_holding;
    logic              r_first;
    logic              r_out_valid;
    t_beat             r_beat;
    t_beat             n_beat;
    logic              w_load;

    always_comb begin
        w_load = i_accept && (r_holding || i_info.last);
        if (r_holding) begin
            n_beat = '{beat_low: r_held_word, beat_high: i_word,
                       mask_low: r_held_mask, mask_high: i_info.mask,
                       start_of_packet: r_first, end_of_packet: i_info.last};
        end else begin
            n_beat = '{beat_low: i_word, beat_high: '0,
                       mask_low: i_info.mask, mask_high: '0,
                       start_of_packet: r_first, end_of_packet: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holding   <= 1'b0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                if (r_holding) begin
                    r_holding <= 1'b0;
                    r_first   <= i_info.last;
                end else if (i_info.last) begin
                    r_first   <= 1'b1;
                end else begin
                    r_holding <= 1'b1;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !r_holding) begin
            r_held_word <= i_word;
            r_held_mask <= i_info.mask;
        end
        if (w_load) begin
            r_beat <= n_beat;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_beat                 = r_beat;
    assign o_status.holding       = r_holding;
    assign o_status.first_pending = r_first;

endmodule

`default_nettype wire

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pbp_pkg::*;

    // Scoreboard: a cycle-free model of the packer. Each accepted word runs
    // through the length tracker and the pairing stage, and every finished
    // beat is queued until the matching beat leaves the block.
    class packer_scoreboard;
        logic [WORD_W-1:0] held_word;
        logic [MASK_W-1:0] held_mask;
        bit                holding_low;
        int unsigned       bytes_left;
        bit                first_pending;
        t_beat             expected_beats[$];
        int unsigned       mismatches;
        int unsigned       beats_checked;

        function new();
            held_word     = '0;
            held_mask     = '0;
            holding_low   = 1'b0;
            bytes_left    = 0;
            first_pending = 1'b1;
            mismatches    = 0;
            beats_checked = 0;
        endfunction

        function int unsigned pending_beats();
            return expected_beats.size();
        endfunction

        function void note_word(logic [WORD_W-1:0] word, logic [PKT_LEN_W-1:0] length);
            int unsigned       left;
            logic [MASK_W:0]   ones;
            logic [MASK_W-1:0] mask;
            bit                last;
            t_beat             beat;
            left = bytes_left;
            if (left == 0) begin
                left = length;
                if (left > MAX_PACKET_BYTES_DEF) begin
                    left = MAX_PACKET_BYTES_DEF;
                end
            end
            if (left > BYTES_PER_WORD) begin
                mask = MASK_FULL;
                left = left - BYTES_PER_WORD;
                last = 1'b0;
            end else begin
                ones = ({{MASK_W{1'b0}}, 1'b1} << left) - 1'b1;
                mask = ones[MASK_W-1:0];
                left = 0;
                last = 1'b1;
            end
            bytes_left = left;

            if (holding_low) begin
                beat.beat_low        = held_word;
                beat.beat_high       = word;
                beat.mask_low        = held_mask;
                beat.mask_high       = mask;
                beat.start_of_packet = first_pending;
                beat.end_of_packet   = last;
                expected_beats.insert(expected_beats.size(), beat);
                holding_low   = 1'b0;
                held_word     = '0;
                held_mask     = '0;
                first_pending = last;
            end else if (last) begin
                beat.beat_low        = word;
                beat.beat_high       = '0;
                beat.mask_low        = mask;
                beat.mask_high       = '0;
                beat.start_of_packet = first_pending;
                beat.end_of_packet   = 1'b1;
                expected_beats.insert(expected_beats.size(), beat);
                first_pending = 1'b1;
            end else begin
                held_word   = word;
                held_mask   = mask;
                holding_low = 1'b1;
            end
        endfunction

        function void check_beat(t_beat got);
            t_beat want;
            if (expected_beats.size() == 0) begin
                $error("unexpected beat: beat_low %h beat_high %h", got.beat_low, got.beat_high);
                mismatches++;
                return;
            end
            want = expected_beats.pop_front();
            beats_checked++;
            if (got.beat_low !== want.beat_low) begin
                $error("beat_low: expected %h, actual %h", want.beat_low, got.beat_low);
                mismatches++;
            end
            if (got.beat_high !== want.beat_high) begin
                $error("beat_high: expected %h, actual %h", want.beat_high, got.beat_high);
                mismatches++;
            end
            if (got.mask_low !== want.mask_low) begin
                $error("mask_low: expected %h, actual %h", want.mask_low, got.mask_low);
                mismatches++;
            end
            if (got.mask_high !== want.mask_high) begin
                $error("mask_high: expected %h, actual %h", want.mask_high, got.mask_high);
                mismatches++;
            end
            if (got.start_of_packet !== want.start_of_packet) begin
                $error("start_of_packet: expected %b, actual %b",
                       want.start_of_packet, got.start_of_packet);
                mismatches++;
            end
            if (got.end_of_packet !== want.end_of_packet) begin
                $error("end_of_packet: expected %b, actual %b",
                       want.end_of_packet, got.end_of_packet);
                mismatches++;
            end
        endfunction
    endclass

    // Random word count of the main phase, the length of the one long packet,
    // and the number of quiet cycles after which the run is declared hung.
    localparam int unsigned RANDOM_WORDS     = 1700;
    localparam int unsigned BIG_PACKET_BYTES = 4096;
    localparam int unsigned QUIET_LIMIT      = 2000;

    logic i_clk;
    logic i_rst_n;

    pbp_in_if  word_ch ();
    pbp_out_if beat_ch ();

    packer_scoreboard sb = new();

    // Random idling on both sides is enabled through most of the run and is
    // switched off for the final stretch.
    bit          idle_on = 1'b1;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned words_sent = 0;
    int unsigned packets_sent = 0;
    int unsigned zero_length_packets = 0;

    packet_beat_packer_64_to_128 DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (word_ch),
        .o_out   (beat_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Every accepted input request goes straight into the model. Sampling at
    // the rising edge sees the values that the block itself sampled.
    always @(posedge i_clk) begin
        if (i_rst_n && word_ch.valid && word_ch.ready) begin
            sb.note_word(word_ch.data_word, word_ch.packet_length);
        end
    end

    // Every accepted output request is checked against the oldest predicted beat.
    always @(posedge i_clk) begin
        t_beat got;
        if (i_rst_n && beat_ch.valid && beat_ch.ready) begin
            got.beat_low        = beat_ch.beat_low;
            got.beat_high       = beat_ch.beat_high;
            got.mask_low        = beat_ch.mask_low;
            got.mask_high       = beat_ch.mask_high;
            got.start_of_packet = beat_ch.start_of_packet;
            got.end_of_packet   = beat_ch.end_of_packet;
            sb.check_beat(got);
        end
    end

    // The receiver stalls in bursts whose length is drawn at random when each burst
    // starts. A new burst may start right after the previous one, so stalls can land on any cycle of a beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            beat_ch.ready <= 1'b0;
            stall_left    <= 0;
        end else if (stall_left != 0) begin
            beat_ch.ready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            beat_ch.ready <= 1'b0;
            stall_left    <= $urandom_range(0, 17);
        end else begin
            beat_ch.ready <= 1'b1;
        end
    end

    // The hang detector counts cycles in which neither side moves a request.
    always @(posedge i_clk) begin
        if ((word_ch.valid && word_ch.ready) || (beat_ch.valid && beat_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
        end
        $display("[packet_beat_packer_64_to_128] ERROR");
        $finish;
    end

    // Presents one word and returns at the edge where it is accepted. When
    // idling is on, a random gap with valid low may come first. valid stays
    // high from one word to the next, so back-to-back requests need no extra
    // assignment in the same step.
    task automatic send_word(input logic [WORD_W-1:0] word,
                             input logic [PKT_LEN_W-1:0] length);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            word_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        word_ch.valid         <= 1'b1;
        word_ch.data_word     <= word;
        word_ch.packet_length <= length;
        do begin
            @(posedge i_clk);
        end while (!word_ch.ready);
        words_sent++;
    endtask

    // Sends one whole packet. Only the first word carries the real length;
    // the later words carry random length values that the block must ignore.
    // A zero length still takes one word.
    task automatic send_packet(input int unsigned length);
        int unsigned       word_count;
        logic [WORD_W-1:0] word;
        word_count = (length == 0) ? 1 : (length + BYTES_PER_WORD - 1) / BYTES_PER_WORD;
        for (int unsigned i = 0; i < word_count; i++) begin
            case ($urandom_range(0, 7))
                0:       word = '1;
                1:       word = '0;
                default: word = {$urandom, $urandom};
            endcase
            if (i == 0) begin
                send_word(word, PKT_LEN_W'(length));
            end else begin
                send_word(word, PKT_LEN_W'($urandom));
            end
        end
        packets_sent++;
        if (length == 0) begin
            zero_length_packets++;
        end
    endtask

    // Holds the sender off until every predicted beat has left the block.
    task automatic drain_beats();
        word_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_beats() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int unsigned quota_base;
        int unsigned length;
        bit          big_sent;
        bit          drained;

        word_ch.valid         = 1'b0;
        word_ch.data_word     = '0;
        word_ch.packet_length = '0;
        beat_ch.ready         = 1'b0;
        i_rst_n               = 1'b0;
        big_sent              = 1'b0;
        drained               = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. A zero-length packet is a single word with an empty
        // mask that leaves at once as a padded last beat; it is tried first
        // after reset and again right after other packets.
        send_packet(0);
        send_packet(1);
        send_packet(8);
        send_packet(9);
        send_packet(16);
        // A 17-byte packet whose later words carry the extreme length values,
        // which must not restart the packet.
        send_word('1, PKT_LEN_W'(17));
        send_word('0, '0);
        send_word({$urandom, $urandom}, '1);
        packets_sent++;
        send_packet(7);
        send_packet(0);
        send_packet(24);
        send_packet(32);

        // Random part. Most packets are short so that packet boundaries and
        // odd last words come often; one packet is long.
        quota_base = words_sent;
        while (words_sent - quota_base < RANDOM_WORDS) begin
            case ($urandom_range(0, 19))
                0:                            length = 0;
                1, 2, 3, 4, 5, 6, 7, 8, 9:    length = $urandom_range(1, 32);
                10, 11, 12, 13, 14, 15:       length = $urandom_range(33, 128);
                16, 17:                       length = $urandom_range(129, 1024);
                default:                      length = $urandom_range(1, 8);
            endcase
            send_packet(length);

            if (!big_sent && words_sent - quota_base >= 300) begin
                send_packet(BIG_PACKET_BYTES);
                big_sent = 1'b1;
            end
            if (!drained && words_sent - quota_base >= 700) begin
                drain_beats();
                drained = 1'b1;
            end
            if (words_sent - quota_base >= RANDOM_WORDS - 300) begin
                idle_on = 1'b0;
            end
        end

        // Wait for the last beats, then a short tail in which nothing more
        // may come out.
        word_ch.valid <= 1'b0;
        while (sb.pending_beats() != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);

        $display("Sent %0d packets in %0d words, %0d of them zero-length, one of %0d bytes.",
                 packets_sent, words_sent, zero_length_packets, BIG_PACKET_BYTES);
        $display("Checked %0d beats under random stalls on both sides, with one full drain.",
                 sb.beats_checked);
        if (sb.mismatches == 0) begin
            $display("[packet_beat_packer_64_to_128] OK");
        end else begin
            $display("[packet_beat_packer_64_to_128] ERROR");
        end
        $finish;
    end
endmodule

// File: files.f
rtl/pbp_pkg.sv
rtl/pbp_stream_if.sv
rtl/pbp_len.sv
rtl/pbp_pair.sv
rtl/packet_beat_packer_64_to_128.sv
tb/tb.sv
